>>> rtl/ldfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldfs_pkg
// Shared types, widths and helper functions of the solar-to-lunar date unit.
// ----------------------------------------------------------------------------
package ldfs_pkg;

  localparam int TABLE_YEARS = 256;
  localparam int IDX_W       = $clog2(TABLE_YEARS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int INFO_W      = 17;
  localparam int OFF_W       = 25;
  localparam int LEN_W       = 9;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef logic [INFO_W-1:0] info_t;

  // Cumulative day count at the start of each shifted month (March first).
  function automatic logic [8:0] doy_start(input logic [3:0] mm);
    logic [8:0] r;
    unique case (mm)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      4'd12:   r = 9'd367;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic month_long(input info_t w, input logic [3:0] m);
    logic [4:0] bit_idx;
    bit_idx = 5'd16 - {1'b0, m};
    if (m < 4'd1 || m > 4'd12) begin
      return 1'b0;
    end
    return w[bit_idx];
  endfunction

  function automatic logic [LEN_W-1:0] year_len(input info_t w);
    logic [LEN_W-1:0] total;
    total = LEN_W'(348);
    for (int i = 4; i <= 15; i++) begin
      total = total + LEN_W'(w[i]);
    end
    if (w[3:0] != 4'd0) begin
      total = total + LEN_W'(29) + LEN_W'(w[16]);
    end
    return total;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ldfs_year_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldfs_year_ram
// Year info table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ldfs_year_ram (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [ldfs_pkg::IDX_W-1:0] waddr_i,
  input  wire ldfs_pkg::info_t          wdata_i,
  input  wire logic [ldfs_pkg::IDX_W-1:0] raddr_i,
  output      ldfs_pkg::info_t          rdata_o
);
  import ldfs_pkg::*;

  info_t mem_q [TABLE_YEARS];
  info_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/lunar_date_from_solar_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lunar_date_from_solar_unit
// Gregorian date to Chinese lunar month, day and leap flag, driven by a
// loadable table of packed year info words.
// ----------------------------------------------------------------------------
// A load item writes one year info word into the table and presents an all-zero
// result. A convert item first forms the day offset from the epoch: it strips
// one 400-year era step per cycle in state S_DIV, then does the day-count
// arithmetic in states S_DN1 and S_DN2. It then walks the table one year per
// cycle, bound by the single read port of the year table, then one lunar month
// per cycle, and delivers the result from state S_RESP, which waits while the
// output register holds a result not yet taken. The input side stays not ready
// until the result is handed to the output register; that register holds it
// while the next item is taken. Every table entry a conversion reaches must
// have been loaded beforehand.
// ----------------------------------------------------------------------------
module lunar_date_from_solar_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [16:0] entry_word_i,
  input  wire logic [13:0] solar_year_i,
  input  wire logic [3:0]  solar_month_i,
  input  wire logic [4:0]  solar_day_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic        valid_res_o,
  output      logic [3:0]  lunar_month_o,
  output      logic [4:0]  lunar_day_o,
  output      logic        leap_flag_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  import ldfs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_DN1   = 3'd2;
  localparam logic [2:0] S_DN2   = 3'd3;
  localparam logic [2:0] S_YWALK = 3'd4;
  localparam logic [2:0] S_MWALK = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  localparam logic [13:0] ERA_YEARS = 14'd400;

  logic [2:0]  state_q, state_d;
  logic [13:0] first_year_q;
  logic signed [22:0] epoch_q;
  logic        out_valid_q, out_valid_d;

  logic [13:0] v_q, v_d;
  logic [4:0]  era_q, era_d;
  logic [3:0]  mm_q, mm_d;
  logic [4:0]  day_q, day_d;
  logic signed [OFF_W-1:0] offset_q, offset_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [LEN_W-1:0] temp_q, temp_d;
  logic [3:0]  j_q, j_d;
  logic        isl_q, isl_d;
  logic        res_valid_q, res_valid_d;
  logic [3:0]  res_month_q, res_month_d;
  logic [4:0]  res_day_q, res_day_d;
  logic        res_leap_q, res_leap_d;
  logic        ov_res_q, ov_res_d;
  logic [3:0]  ov_month_q, ov_month_d;
  logic [4:0]  ov_day_q, ov_day_d;
  logic        ov_leap_q, ov_leap_d;

  logic        accept;
  logic        mem_we;
  info_t       rdata;
  logic signed [OFF_W-1:0] add_b, add_sum;

  logic [8:0]  yoe;
  logic [17:0] yoe_prod;
  logic [1:0]  cent;
  logic signed [OFF_W-1:0] dn1_sum;
  logic [21:0] era_prod;
  logic [LEN_W-1:0] ylen;

  logic [3:0]  leap;
  logic [4:0]  leap_p1;
  logic        take_leap;
  logic [3:0]  jj_walk;
  logic        isl_walk;
  logic [LEN_W-1:0] mlen;
  logic [3:0]  jj_fix;
  logic        isl_fix;

  ldfs_year_ram u_year_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (entry_index_i[IDX_W-1:0]),
    .wdata_i (entry_word_i),
    .raddr_i (idx_d[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign accept  = in_valid_i && in_ready_o;
  assign add_sum = offset_q + add_b;

  assign yoe      = v_q[8:0];
  assign yoe_prod = 18'(yoe) * 18'd365;
  assign cent     = (yoe >= 9'd300) ? 2'd3 :
                    (yoe >= 9'd200) ? 2'd2 :
                    (yoe >= 9'd100) ? 2'd1 : 2'd0;
  assign dn1_sum  = $signed(OFF_W'(yoe_prod)) + $signed(OFF_W'(yoe >> 2))
                  - $signed(OFF_W'(cent)) + $signed(OFF_W'(doy_start(mm_q)))
                  + $signed(OFF_W'(day_q)) - OFF_W'(865566)
                  - OFF_W'(epoch_q);
  assign era_prod = 22'(era_q) * 22'd146097;
  assign ylen     = year_len(rdata);

  always_comb begin
    leap      = rdata[3:0];
    leap_p1   = {1'b0, leap} + 5'd1;
    take_leap = (leap != 4'd0) && ({1'b0, j_q} == leap_p1) && !isl_q;
    jj_walk   = take_leap ? (j_q - 4'd1) : j_q;
    isl_walk  = take_leap | isl_q;
    if (isl_walk && ({1'b0, jj_walk} == leap_p1)) begin
      isl_walk = 1'b0;
    end
    mlen = take_leap ? (LEN_W'(29) + LEN_W'(rdata[16]))
                     : (LEN_W'(29) + LEN_W'(month_long(rdata, j_q)));
    jj_fix  = j_q;
    isl_fix = isl_q;
    if (offset_q == '0 && leap != 4'd0 && {1'b0, j_q} == leap_p1) begin
      if (isl_q) begin
        isl_fix = 1'b0;
      end else begin
        isl_fix = 1'b1;
        jj_fix  = j_q - 4'd1;
      end
    end
    if (offset_q < 0) begin
      jj_fix = jj_fix - 4'd1;
    end
  end

  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    era_d       = era_q;
    mm_d        = mm_q;
    day_d       = day_q;
    offset_d    = offset_q;
    idx_d       = idx_q;
    temp_d      = temp_q;
    j_d         = j_q;
    isl_d       = isl_q;
    res_valid_d = res_valid_q;
    res_month_d = res_month_q;
    res_day_d   = res_day_q;
    res_leap_d  = res_leap_q;
    ov_res_d    = ov_res_q;
    ov_month_d  = ov_month_q;
    ov_day_d    = ov_day_q;
    ov_leap_d   = ov_leap_q;
    out_valid_d = out_valid_q;
    add_b       = '0;
    mem_we      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b0;
          res_month_d = '0;
          res_day_d   = '0;
          res_leap_d  = 1'b0;
          if (operation_i == OP_LOAD) begin
            mem_we  = 1'b1;
            state_d = S_RESP;
          end else begin
            v_d     = solar_year_i + ERA_YEARS - 14'(solar_month_i <= 4'd2);
            mm_d    = (solar_month_i > 4'd2) ? (solar_month_i - 4'd3)
                                              : (solar_month_i + 4'd9);
            day_d   = solar_day_i;
            era_d   = '0;
            idx_d   = '0;
            temp_d  = '0;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (v_q >= ERA_YEARS) begin
          v_d   = v_q - ERA_YEARS;
          era_d = era_q + 5'd1;
        end else begin
          state_d = S_DN1;
        end
      end
      S_DN1: begin
        offset_d = dn1_sum;
        state_d  = S_DN2;
      end
      S_DN2: begin
        add_b    = $signed(OFF_W'(era_prod));
        offset_d = add_sum;
        state_d  = S_YWALK;
      end
      S_YWALK: begin
        if (offset_q > 0 && idx_q < CNT_W'(TABLE_YEARS)) begin
          add_b    = -$signed(OFF_W'(ylen));
          offset_d = add_sum;
          temp_d   = ylen;
          idx_d    = idx_q + CNT_W'(1);
        end else if (offset_q < 0) begin
          if (idx_q == '0) begin
            state_d = S_RESP;
          end else begin
            add_b    = $signed(OFF_W'(temp_q));
            offset_d = add_sum;
            idx_d    = idx_q - CNT_W'(1);
            j_d      = 4'd1;
            isl_d    = 1'b0;
            state_d  = S_MWALK;
          end
        end else if (idx_q >= CNT_W'(TABLE_YEARS)) begin
          state_d = S_RESP;
        end else begin
          j_d     = 4'd1;
          isl_d   = 1'b0;
          state_d = S_MWALK;
        end
      end
      S_MWALK: begin
        if (j_q < 4'd13 && offset_q > 0) begin
          add_b    = -$signed(OFF_W'(mlen));
          offset_d = add_sum;
          temp_d   = mlen;
          j_d      = jj_walk + 4'd1;
          isl_d    = isl_walk;
        end else begin
          if (offset_q < 0) begin
            add_b = $signed(OFF_W'(temp_q));
          end
          res_valid_d = 1'b1;
          res_month_d = jj_fix;
          res_day_d   = add_sum[4:0] + 5'd1;
          res_leap_d  = isl_fix;
          state_d     = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ov_res_d    = res_valid_q;
          ov_month_d  = res_month_q;
          ov_day_d    = res_day_q;
          ov_leap_d   = res_leap_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      first_year_q <= 14'd1900;
      epoch_q      <= -23'sd25537;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && pready) begin
        if (paddr[2]) begin
          epoch_q <= pwdata[22:0];
        end else begin
          first_year_q <= pwdata[13:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    era_q       <= era_d;
    mm_q        <= mm_d;
    day_q       <= day_d;
    offset_q    <= offset_d;
    idx_q       <= idx_d;
    temp_q      <= temp_d;
    j_q         <= j_d;
    isl_q       <= isl_d;
    res_valid_q <= res_valid_d;
    res_month_q <= res_month_d;
    res_day_q   <= res_day_d;
    res_leap_q  <= res_leap_d;
    ov_res_q    <= ov_res_d;
    ov_month_q  <= ov_month_d;
    ov_day_q    <= ov_day_d;
    ov_leap_q   <= ov_leap_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign valid_res_o   = ov_res_q;
  assign lunar_month_o = ov_month_q;
  assign lunar_day_o   = ov_day_q;
  assign leap_flag_o   = ov_leap_q;
  assign pready        = 1'b1;
  assign prdata        = paddr[2] ? {{9{epoch_q[22]}}, epoch_q}
                                  : {18'd0, first_year_q};

endmodule
`default_nettype wire

>>> verif/lunar_date_checker.sv
// ----------------------------------------------------------------------------
// lunar_date_checker
// Watches the item, result and register ports of the solar-to-lunar date
// unit. It keeps its own year table and epoch day, works out the lunar date
// of every accepted conversion and compares each result transfer, field by
// field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lunar_date_checker
  import ldfs_pkg::*;
#(
  parameter logic [2:0] EPOCH_ADDR     = 3'd4,
  parameter longint     EPOCH_AT_RESET = -25537
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  entry_index_i,
  input  logic [16:0] entry_word_i,
  input  logic [13:0] solar_year_i,
  input  logic [3:0]  solar_month_i,
  input  logic [4:0]  solar_day_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic        valid_res_o,
  input  logic [3:0]  lunar_month_o,
  input  logic [4:0]  lunar_day_o,
  input  logic        leap_flag_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending_results,
  output int          results_checked,
  output int          valid_dates
);

  localparam longint MARCH_ZERO_OFFSET = 719468;
  localparam longint ERA_DAYS          = 146097;
  localparam int     BASE_YEAR_DAYS    = 348;

  typedef struct packed {
    logic       valid_res;
    logic [3:0] month;
    logic [4:0] day;
    logic       leap;
  } lunar_result_t;

  info_t         year_table [TABLE_YEARS];
  longint        epoch_days;
  lunar_result_t lunar_dates_due [$];
  int            errors;
  int            checked;
  int            valid_seen;

  function automatic longint gregorian_day_number(longint y, longint m, longint d);
    longint yy, era, yoe, mm, doy, doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = ((yy >= 0) ? yy : yy - 399) / 400;
    yoe = yy - era * 400;
    mm  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mm + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * ERA_DAYS + doe - MARCH_ZERO_OFFSET;
  endfunction

  function automatic int month_span(info_t w, int m);
    if (m < 1 || m > 12) begin
      return 29;
    end
    return w[16 - m] ? 30 : 29;
  endfunction

  function automatic int lunar_year_span(info_t w);
    int total;
    total = BASE_YEAR_DAYS;
    for (int m = 1; m <= 12; m++) begin
      if (month_span(w, m) == 30) begin
        total++;
      end
    end
    if (w[3:0] != 4'd0) begin
      total += w[16] ? 30 : 29;
    end
    return total;
  endfunction

  function automatic lunar_result_t convert_date(logic [13:0] y, logic [3:0] m,
                                                 logic [4:0] d);
    lunar_result_t r;
    longint        remain;
    int            yr, span, leap_month, mon;
    bit            in_leap;
    info_t         w;
    r       = '0;
    yr      = 0;
    span    = 0;
    mon     = 1;
    in_leap = 1'b0;
    remain  = gregorian_day_number(longint'(y), longint'(m), longint'(d)) - epoch_days;
    while (remain > 0 && yr < TABLE_YEARS) begin
      span = lunar_year_span(year_table[yr]);
      remain -= span;
      yr++;
    end
    if (remain < 0) begin
      remain += span;
      yr--;
    end
    if (yr < 0 || yr >= TABLE_YEARS) begin
      return r;
    end
    w          = year_table[yr];
    leap_month = int'(w[3:0]);
    while (mon < 13 && remain > 0) begin
      if (leap_month > 0 && mon == leap_month + 1 && !in_leap) begin
        mon--;
        in_leap = 1'b1;
        span    = w[16] ? 30 : 29;
      end else begin
        span = month_span(w, mon);
      end
      if (in_leap && mon == leap_month + 1) begin
        in_leap = 1'b0;
      end
      remain -= span;
      mon++;
    end
    if (remain == 0 && leap_month > 0 && mon == leap_month + 1) begin
      if (in_leap) begin
        in_leap = 1'b0;
      end else begin
        in_leap = 1'b1;
        mon--;
      end
    end
    if (remain < 0) begin
      remain += span;
      mon--;
    end
    r.valid_res = 1'b1;
    r.month     = 4'(mon);
    r.day       = 5'(remain + 1);
    r.leap      = in_leap;
    return r;
  endfunction

  task automatic compare_result();
    lunar_result_t want;
    if (lunar_dates_due.size() == 0) begin
      $error("result transfer with no prediction outstanding");
      errors++;
      return;
    end
    want = lunar_dates_due.pop_front();
    checked++;
    if (valid_res_o) begin
      valid_seen++;
    end
    if (valid_res_o !== want.valid_res) begin
      $error("valid_res: expected %0d, got %0d", want.valid_res, valid_res_o);
      errors++;
    end
    if (lunar_month_o !== want.month) begin
      $error("lunar_month: expected %0d, got %0d", want.month, lunar_month_o);
      errors++;
    end
    if (lunar_day_o !== want.day) begin
      $error("lunar_day: expected %0d, got %0d", want.day, lunar_day_o);
      errors++;
    end
    if (leap_flag_o !== want.leap) begin
      $error("leap_flag: expected %0d, got %0d", want.leap, leap_flag_o);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_YEARS; i++) begin
        year_table[i] = '0;
      end
      lunar_dates_due.delete();
      epoch_days      = EPOCH_AT_RESET;
      errors          = 0;
      checked         = 0;
      valid_seen      = 0;
      mismatches      <= 0;
      pending_results <= 0;
      results_checked <= 0;
      valid_dates     <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        compare_result();
      end
      if (in_valid_i && in_ready_o) begin
        if (operation_i == OP_LOAD) begin
          year_table[entry_index_i] = entry_word_i;
          lunar_dates_due.push_back('0);
        end else begin
          lunar_dates_due.push_back(convert_date(solar_year_i, solar_month_i, solar_day_i));
        end
      end
      if (psel && penable && pwrite && pready && paddr == EPOCH_ADDR) begin
        epoch_days = longint'($signed(pwdata[22:0]));
      end
      mismatches      <= errors;
      pending_results <= lunar_dates_due.size();
      results_checked <= checked;
      valid_dates     <= valid_seen;
    end
  end

endmodule

>>> verif/lunar_date_from_solar_unit_test.sv
// ----------------------------------------------------------------------------
// lunar_date_from_solar_unit_test
// Fills the year table, runs directed boundary dates, then random loads and
// conversions under three epoch settings and sender/receiver stall mixes,
// and boundary dates at a fourth; a checker predicts and checks every result.
// ----------------------------------------------------------------------------
module lunar_date_from_solar_unit_test;
  import ldfs_pkg::*;

  localparam logic [2:0] REG_FIRST_YEAR = 3'd0;
  localparam logic [2:0] REG_EPOCH_DAY  = 3'd4;
  localparam longint     EPOCH_1900     = -25537;
  localparam longint     EPOCH_LOW      = -719468;
  localparam longint     EPOCH_HIGH     = 2932896;
  localparam int         PHASE_ITEMS    = 490;
  localparam int         DRAIN_CYCLES   = 400;
  localparam int         CYCLE_LIMIT    = 3_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        operation_i;
  logic [7:0]  entry_index_i;
  logic [16:0] entry_word_i;
  logic [13:0] solar_year_i;
  logic [3:0]  solar_month_i;
  logic [4:0]  solar_day_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        valid_res_o;
  logic [3:0]  lunar_month_o;
  logic [4:0]  lunar_day_o;
  logic        leap_flag_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          pending_results;
  int          results_checked;
  int          valid_dates;
  int          in_idle_pct;
  int          out_idle_pct;
  int          loads_sent;
  int          converts_sent;
  longint      base_year;
  int unsigned cycle_count;

  lunar_date_from_solar_unit dut (.*);

  lunar_date_checker #(
    .EPOCH_ADDR     (REG_EPOCH_DAY),
    .EPOCH_AT_RESET (EPOCH_1900)
  ) u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic apb_access(input logic [2:0] addr, input logic [31:0] data);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    penable <= 1'b0;
  endtask

  task automatic set_registers(input logic [13:0] year0, input longint epoch);
    apb_access(REG_FIRST_YEAR, 32'(year0));
    apb_access(REG_EPOCH_DAY, 32'(epoch));
    psel   <= 1'b0;
    pwrite <= 1'b0;
    base_year = 1970 + (epoch * 400) / 146097;
  endtask

  task automatic send_item(input logic op, input logic [7:0] idx, input logic [16:0] word,
                           input logic [13:0] yr, input logic [3:0] mon,
                           input logic [4:0] day);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    entry_index_i <= idx;
    entry_word_i  <= word;
    solar_year_i  <= yr;
    solar_month_i <= mon;
    solar_day_i   <= day;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (op == OP_LOAD) begin
      loads_sent++;
    end else begin
      converts_sent++;
    end
  endtask

  task automatic send_load(input logic [7:0] idx, input logic [16:0] word);
    send_item(OP_LOAD, idx, word, 14'($urandom), 4'($urandom), 5'($urandom));
  endtask

  task automatic send_convert(input logic [13:0] yr, input logic [3:0] mon,
                              input logic [4:0] day);
    send_item(OP_CONVERT, 8'($urandom), 17'($urandom), yr, mon, day);
  endtask

  task automatic release_and_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  // mostly calendar-like words; one in ten fully random
  function automatic logic [16:0] year_word();
    logic [16:0] w;
    w = 17'($urandom);
    if ($urandom_range(9) != 0) begin
      w[3:0] = ($urandom_range(2) == 0) ? 4'($urandom_range(12, 1)) : 4'd0;
      if (w[3:0] == 4'd0) begin
        w[16] = 1'b0;
      end
    end
    return w;
  endfunction

  task automatic send_random_date();
    longint     y;
    logic [3:0] m;
    logic [4:0] d;
    if ($urandom_range(6) != 0) begin
      y = base_year + longint'($urandom_range(262)) - 2;
    end else begin
      y = longint'($urandom_range(9999));
    end
    if (y < 0) begin
      y = 0;
    end else if (y > 9999) begin
      y = 9999;
    end
    if ($urandom_range(7) == 0) begin
      m = 4'($urandom);
      d = 5'($urandom);
    end else begin
      m = 4'($urandom_range(12, 1));
      d = 5'($urandom_range(31, 1));
    end
    send_convert(14'(y), m, d);
  endtask

  task automatic random_phase();
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(99) < 35) begin
        send_load(8'($urandom_range(TABLE_YEARS - 1)), year_word());
      end else begin
        send_random_date();
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    operation_i   <= OP_LOAD;
    entry_index_i <= '0;
    entry_word_i  <= '0;
    solar_year_i  <= '0;
    solar_month_i <= '0;
    solar_day_i   <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_idle_pct   = 23;
    out_idle_pct  = 52;
    loads_sent    = 0;
    converts_sent = 0;
    cycle_count   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_registers(14'd1900, EPOCH_1900);

    // fill every entry before any conversion walks the table
    for (int i = 0; i < TABLE_YEARS; i++) begin
      send_load(8'(i), year_word());
    end

    send_load(8'd0, 17'h00000);
    send_load(8'd255, 17'h1FFFF);
    send_load(8'd1, 17'h1AB5C);
    send_load(8'd2, 17'h05A5F);
    send_load(8'd3, 17'h12D46);
    send_convert(14'd1900, 4'd1, 5'd31);
    send_convert(14'd1900, 4'd1, 5'd30);
    send_convert(14'd0, 4'd0, 5'd0);
    send_convert(14'd9999, 4'd15, 5'd31);
    send_convert(14'd1900, 4'd2, 5'd28);
    send_convert(14'd1900, 4'd3, 5'd1);
    send_convert(14'd1901, 4'd3, 5'd15);
    send_convert(14'd1901, 4'd12, 5'd31);
    send_convert(14'd1902, 4'd6, 5'd10);
    send_convert(14'd1903, 4'd2, 5'd15);
    send_convert(14'd1903, 4'd6, 5'd30);
    send_convert(14'd1903, 4'd8, 5'd30);
    send_convert(14'd1903, 4'd9, 5'd16);
    send_convert(14'd1901, 4'd13, 5'd5);
    send_convert(14'd1902, 4'd0, 5'd10);
    send_convert(14'd1902, 4'd5, 5'd0);
    send_convert(14'd1902, 4'd2, 5'd31);
    random_phase();

    release_and_drain();
    in_idle_pct  = 52;
    out_idle_pct = 23;
    set_registers(14'd0, EPOCH_LOW);
    random_phase();

    release_and_drain();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_registers(14'($urandom_range(9999)), EPOCH_LOW + longint'($urandom_range(3652364)));
    random_phase();

    release_and_drain();
    set_registers(14'd9999, EPOCH_HIGH);
    send_convert(14'd9999, 4'd12, 5'd31);
    send_convert(14'd9999, 4'd12, 5'd30);
    send_convert(14'd9999, 4'd13, 5'd1);
    send_convert(14'd9999, 4'd15, 5'd31);
    send_convert(14'd9999, 4'd12, 5'd1);

    release_and_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run: %0d table loads and %0d date conversions over four epoch settings",
             loads_sent, converts_sent);
    $display("run: %0d results checked, %0d valid lunar dates, %0d mismatches",
             results_checked, valid_dates, mismatches);
    if (mismatches == 0 && pending_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ldfs_pkg.sv
rtl/ldfs_year_ram.sv
rtl/lunar_date_from_solar_unit.sv
verif/lunar_date_checker.sv
verif/lunar_date_from_solar_unit_test.sv
